[sv/rc4_stream_cipher_macros.svh]
// Assertion macros shared by the RC4 checker.
// Expects signals named clock and reset in the scope of use.
`ifndef RC4_STREAM_CIPHER_MACROS_SVH
`define RC4_STREAM_CIPHER_MACROS_SVH

// same-cycle implication
`define RC4_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RC4_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/rc4_pkg.sv]
// Shared constants and types for the RC4 stream cipher.
// No dependencies.
package rc4_pkg;

   localparam int SboxDepth = 256;
   localparam int IdxW      = $clog2(SboxDepth);
   localparam int KeyBytes  = 16;
   localparam int KpW       = (KeyBytes > 1) ? $clog2(KeyBytes) : 1;
   localparam int KeyLenW   = 5;
   localparam int CsrAddrW  = 5;
   localparam int CsrDataW  = 64;
   localparam int RegIdxW   = 2;

   localparam logic [RegIdxW-1:0] RegKeyLow  = 2'd0;
   localparam logic [RegIdxW-1:0] RegKeyHigh = 2'd1;
   localparam logic [RegIdxW-1:0] RegKeyLen  = 2'd2;

   typedef struct packed {
      logic            we;
      logic [IdxW-1:0] waddr;
      logic [IdxW-1:0] wdata;
      logic [IdxW-1:0] raddr;
   } rc4_ram_req_type;

endpackage

[sv/rc4_sbox_ram.sv]
// Permutation store: 256 x 8 memory, one write and one registered read port.
// Depends on rc4_pkg.
module rc4_sbox_ram (
   input  logic                      clock,
   input  rc4_pkg::rc4_ram_req_type  ram_req,
   output logic [rc4_pkg::IdxW-1:0]  rd_data
);
   import rc4_pkg::*;

   logic [IdxW-1:0] mem [SboxDepth];

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.waddr] <= ram_req.wdata;
      end
      rd_data <= mem[ram_req.raddr];
   end

endmodule

[sv/rc4_stream_cipher.sv]
// RC4 stream cipher top level: APB key registers, sequencer, output register.
// Depends on rc4_pkg and rc4_sbox_ram.
//
// Usage:
//  - Load the key through the csr_ port: key_bytes_low at 0x00, key_bytes_high
//    at 0x08, key_length at 0x10 (five bits; zero acts as one, above 16 as 16).
//  - Each req_ transfer carries one data byte and a command. Command 1 starts
//    a message: the permutation is reloaded with identity and the key
//    schedule runs (states KS_RD_K, KS_RD_J, KS_WR_K, KS_WR_J per step),
//    then the byte is processed. Command 0 continues with the current state.
//  - One rsp_ transfer per request. rsp_valid rises after G_RD_I, G_RD_J,
//    G_WR_I, G_WR_J and G_KS; a start item runs reload and key schedule first.
//  - One item is in flight at a time; req_ready is high only in idle, so a
//    new request waits for the sequencer to finish. Each generator step costs
//    two reads, two swap writes and a keystream read on the permutation memory.
//  - The result sits in an output register; the next request is taken while
//    it waits. If rsp_ready stays low, the following result is held inside
//    and req_ready stays low until the output register frees.
//  - Reset: a sweep writes identity into the permutation with req_ready low;
//    i and j clear, key registers return to zero, length to 1.
module rc4_stream_cipher (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_command,
   input  logic [7:0]                     req_data_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [7:0]                     rsp_result_byte,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [rc4_pkg::CsrAddrW-1:0]   csr_paddr,
   input  logic [rc4_pkg::CsrDataW-1:0]   csr_pwdata,
   output logic [rc4_pkg::CsrDataW-1:0]   csr_prdata,
   output logic                           csr_pready
);
   import rc4_pkg::*;

   localparam logic [3:0] ST_INIT    = 4'd0;
   localparam logic [3:0] ST_IDLE    = 4'd1;
   localparam logic [3:0] ST_KS_RD_K = 4'd2;
   localparam logic [3:0] ST_KS_RD_J = 4'd3;
   localparam logic [3:0] ST_KS_WR_K = 4'd4;
   localparam logic [3:0] ST_KS_WR_J = 4'd5;
   localparam logic [3:0] ST_G_RD_I  = 4'd6;
   localparam logic [3:0] ST_G_RD_J  = 4'd7;
   localparam logic [3:0] ST_G_WR_I  = 4'd8;
   localparam logic [3:0] ST_G_WR_J  = 4'd9;
   localparam logic [3:0] ST_G_KS    = 4'd10;
   localparam logic [3:0] ST_OUT     = 4'd11;

   localparam logic [IdxW-1:0] LastIdx = IdxW'(SboxDepth - 1);

   logic [CsrDataW-1:0] key_low_ff, key_high_ff;
   logic [KeyLenW-1:0]  key_len_ff;
   logic [RegIdxW-1:0]  csr_idx;
   logic                csr_wr;

   logic [3:0]          state_ff, state_in;
   logic [IdxW-1:0]     cnt_ff, cnt_in;
   logic [KpW-1:0]      kp_ff, kp_in;
   logic [IdxW-1:0]     i_ff, i_in;
   logic [IdxW-1:0]     j_ff, j_in;
   logic [IdxW-1:0]     si_ff, si_in;
   logic [IdxW-1:0]     sj_ff, sj_in;
   logic [7:0]          data_ff, data_in;
   logic [7:0]          res_ff, res_in;
   logic                ks_pend_ff, ks_pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_byte_ff, rsp_byte_in;

   rc4_ram_req_type     ram_req;
   logic [IdxW-1:0]     rd_data;

   logic [KeyLenW-1:0]  len_eff, kp_inc;
   logic [2*CsrDataW-1:0] key_all;
   logic [7:0]          key_byte;
   logic [IdxW-1:0]     ks_addr, ks_val;
   logic                out_free;
   logic [7:0]          gen_res;

   rc4_sbox_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CsrAddrW-1:3];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
         key_len_ff  <= KeyLenW'(1);
      end else if (csr_wr) begin
         unique case (csr_idx)
            RegKeyLow:  key_low_ff  <= csr_pwdata;
            RegKeyHigh: key_high_ff <= csr_pwdata;
            RegKeyLen:  key_len_ff  <= csr_pwdata[KeyLenW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         RegKeyLow:  csr_prdata = key_low_ff;
         RegKeyHigh: csr_prdata = key_high_ff;
         RegKeyLen:  csr_prdata = {{(CsrDataW-KeyLenW){1'b0}}, key_len_ff};
         default:    csr_prdata = '0;
      endcase
   end

   // key byte selection
   always_comb begin
      if (key_len_ff == '0) begin
         len_eff = KeyLenW'(1);
      end else if (key_len_ff > KeyLenW'(KeyBytes)) begin
         len_eff = KeyLenW'(KeyBytes);
      end else begin
         len_eff = key_len_ff;
      end
   end

   assign key_all  = {key_high_ff, key_low_ff};
   assign key_byte = key_all[kp_ff*8 +: 8];
   assign kp_inc   = KeyLenW'(kp_ff) + KeyLenW'(1);

   assign ks_addr  = si_ff + sj_ff;
   assign ks_val   = (ks_addr == j_ff) ? si_ff : rd_data;
   assign gen_res  = data_ff ^ ks_val;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_byte = rsp_byte_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      kp_in        = kp_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      si_in        = si_ff;
      sj_in        = sj_ff;
      data_in      = data_ff;
      res_in       = res_ff;
      ks_pend_in   = ks_pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      ram_req      = '{we: 1'b0, waddr: cnt_ff, wdata: cnt_ff, raddr: cnt_ff};

      unique case (state_ff)
         ST_INIT: begin
            ram_req.we = 1'b1;
            cnt_in     = cnt_ff + IdxW'(1);
            if (cnt_ff == LastIdx) begin
               state_in = ks_pend_ff ? ST_KS_RD_K : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               data_in = req_data_byte;
               if (req_command) begin
                  state_in   = ST_INIT;
                  cnt_in     = '0;
                  kp_in      = '0;
                  j_in       = '0;
                  ks_pend_in = 1'b1;
               end else begin
                  state_in = ST_G_RD_I;
               end
            end
         end
         ST_KS_RD_K: begin
            state_in = ST_KS_RD_J;
         end
         ST_KS_RD_J: begin
            si_in         = rd_data;
            j_in          = j_ff + rd_data + key_byte;
            ram_req.raddr = j_in;
            state_in      = ST_KS_WR_K;
         end
         ST_KS_WR_K: begin
            ram_req.we    = 1'b1;
            ram_req.wdata = rd_data;
            state_in      = ST_KS_WR_J;
         end
         ST_KS_WR_J: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = j_ff;
            ram_req.wdata = si_ff;
            cnt_in        = cnt_ff + IdxW'(1);
            kp_in         = (kp_inc >= len_eff) ? '0 : kp_inc[KpW-1:0];
            if (cnt_ff == LastIdx) begin
               ks_pend_in = 1'b0;
               i_in       = '0;
               j_in       = '0;
               state_in   = ST_G_RD_I;
            end else begin
               state_in = ST_KS_RD_K;
            end
         end
         ST_G_RD_I: begin
            i_in          = i_ff + IdxW'(1);
            ram_req.raddr = i_in;
            state_in      = ST_G_RD_J;
         end
         ST_G_RD_J: begin
            si_in         = rd_data;
            j_in          = j_ff + rd_data;
            ram_req.raddr = j_in;
            state_in      = ST_G_WR_I;
         end
         ST_G_WR_I: begin
            sj_in         = rd_data;
            ram_req.we    = 1'b1;
            ram_req.waddr = i_ff;
            ram_req.wdata = rd_data;
            state_in      = ST_G_WR_J;
         end
         ST_G_WR_J: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = j_ff;
            ram_req.wdata = si_ff;
            ram_req.raddr = ks_addr;
            state_in      = ST_G_KS;
         end
         ST_G_KS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = gen_res;
               state_in     = ST_IDLE;
            end else begin
               res_in   = gen_res;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         kp_ff        <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         ks_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         kp_ff        <= kp_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         ks_pend_ff   <= ks_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      si_ff       <= si_in;
      sj_ff       <= sj_in;
      data_ff     <= data_in;
      res_ff      <= res_in;
      rsp_byte_ff <= rsp_byte_in;
   end

endmodule

[sv/rc4_stream_cipher_checker.sv]
// Port-level checker for the RC4 stream cipher, bound to the top level.
// Depends on rc4_stream_cipher_macros.svh.
`include "rc4_stream_cipher_macros.svh"

module rc4_stream_cipher_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_result_byte
);

   logic       req_xfer, rsp_xfer;
   logic [1:0] open_ff, open_in;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   always_comb begin
      open_in = open_ff;
      if (req_xfer && !rsp_xfer) begin
         open_in = open_ff + 2'd1;
      end else if (rsp_xfer && !req_xfer) begin
         open_in = open_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   `RC4_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_byte), "result changed while stalled")
   `RC4_ASSERT_IMP(a_no_extra_rsp, rsp_xfer, open_ff != 2'd0, "result transfer without a request")
   `RC4_ASSERT_IMP(a_open_bound, req_xfer, open_ff < 2'd2, "request taken with two results open")
   `RC4_ASSERT_NXT(a_one_in_flight, req_xfer, !req_ready, "second request taken while busy")
   `RC4_ASSERT_IMP(a_reset_sweep, $past(reset), !req_ready && !rsp_valid, "block ready right after reset")

endmodule

bind rc4_stream_cipher rc4_stream_cipher_checker u_rc4_checker (.*);
